@@ design/teh_pkg.sv @@
// Shared constants, types and codes of the two-endstop homing controller.
`default_nettype none

package teh_pkg;

    // Axis position count width.
    localparam int POS_W = 32;

    // Register widths.
    localparam int SPEED_W    = 16;
    localparam int BOFF_W     = 16;
    localparam int CUR_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // The backoff target holds a position plus or minus a backoff count
    // without overflow.
    localparam int BT_W = ((POS_W > BOFF_W) ? POS_W : (BOFF_W + 1)) + 1;

    // Register reset values.
    localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(1000);
    localparam logic [BOFF_W-1:0]  BOFF_RST  = BOFF_W'(200);
    localparam logic [CUR_W-1:0]   CUR_RST   = CUR_W'(800);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOMING_SPEED  = 2'd0,
        CFG_BACKOFF_COUNT = 2'd1,
        CFG_DRIVE_CURRENT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_START  = 2'd1,
        MODE_ABORT  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEEK1  = 3'd1,
        PH_BACK1  = 3'd2,
        PH_SEEK2  = 3'd3,
        PH_BACK2  = 3'd4,
        PH_CENTER = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_HOMING = 2'd1,
        ST_ERROR  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_STOP       = 3'd1,
        CMD_STOP_RUN   = 3'd2,
        CMD_STOP_MOVE  = 3'd3,
        CMD_ENABLE_RUN = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [SPEED_W-1:0] homing_speed;
        logic [BOFF_W-1:0]  backoff_count;
        logic [CUR_W-1:0]   drive_current;
    } t_cfg;

    typedef struct packed {
        logic [1:0]              mode;
        logic                    endstop_one;
        logic                    endstop_two;
        logic signed [POS_W-1:0] position;
        logic                    motor_busy;
    } t_in_item;

    typedef struct packed {
        t_phase                  phase;
        t_status                 status;
        t_cmd                    motor_cmd;
        logic                    motor_forward;
        logic [SPEED_W-1:0]      motor_speed;
        logic signed [POS_W-1:0] target_position;
        logic                    zero_position;
        logic signed [POS_W-1:0] travel_distance;
        logic                    calibrated;
        logic                    save_calibration;
        logic                    display_dirty;
        logic [CUR_W-1:0]        drive_current_out;
    } t_result;

endpackage

`default_nettype wire

@@ design/teh_if.sv @@
// Handshake channels for control ticks in and homing results out.
`default_nettype none

interface teh_in_if;
    import teh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic                    endstop_one;
    logic                    endstop_two;
    logic signed [POS_W-1:0] position;
    logic                    motor_busy;

    modport source (
        output valid, mode, endstop_one, endstop_two, position, motor_busy,
        input  ready
    );
    modport sink (
        input  valid, mode, endstop_one, endstop_two, position, motor_busy,
        output ready
    );
endinterface

interface teh_out_if;
    import teh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              phase;
    logic [1:0]              status;
    logic [2:0]              motor_cmd;
    logic                    motor_forward;
    logic [SPEED_W-1:0]      motor_speed;
    logic signed [POS_W-1:0] target_position;
    logic                    zero_position;
    logic signed [POS_W-1:0] travel_distance;
    logic                    calibrated;
    logic                    save_calibration;
    logic                    display_dirty;
    logic [CUR_W-1:0]        drive_current_out;

    modport source (
        output valid, phase, status, motor_cmd, motor_forward, motor_speed,
               target_position, zero_position, travel_distance, calibrated,
               save_calibration, display_dirty, drive_current_out,
        input  ready
    );
    modport sink (
        input  valid, phase, status, motor_cmd, motor_forward, motor_speed,
               target_position, zero_position, travel_distance, calibrated,
               save_calibration, display_dirty, drive_current_out,
        output ready
    );
endinterface

`default_nettype wire

@@ design/two_endstop_homing_controller.sv @@
// Top level of the two-endstop axis homing controller.
`default_nettype none

// Two-endstop homing sequencer for a stepper axis. Each transfer on the
// input channel is one control tick: a start, an abort or an update that
// carries both endstop switches, the axis position count and the motor busy
// flag. Every tick produces exactly one result transfer with the phase and
// status after the tick, the motor command to issue, and the pulses for
// zeroing the position count, saving the calibration and refreshing the
// display. A start runs backward to endstop one, backs off forward by the
// backoff count and zeroes the position, runs forward to endstop two and
// latches the travel, backs off again, then moves to half the travel
// (truncated toward zero); when that move ends the axis is marked calibrated.
// Endstop two during the first seek stops the motor and reports an error.
// The block takes one tick per clock cycle while the output does not stall;
// a tick passes through the input register and then the result register.
// The sequencer state is updated in the same cycle that the result is
// formed, so consecutive ticks never wait on each other, and the output
// register lets a new tick enter while a result is still waiting. A stall
// on the output backs up through the result register into the input
// register. Registers: 0 homing speed, 1 backoff count, 2 drive current;
// writes to index 3 are ignored. The user must change configuration only
// while no tick is in flight; the block itself does not enforce this.

module two_endstop_homing_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    teh_in_if.sink                              i_in,
    teh_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [teh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [teh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import teh_pkg::*;

    t_cfg     cfg;
    logic     item_valid;
    t_in_item item;
    logic     out_space;
    logic     step;
    t_result  result;

    // A held tick is processed whenever the result register can take it.
    assign step = item_valid && out_space;

    teh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    teh_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (step),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    teh_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    teh_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result),
        .o_space  (out_space),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

@@ design/teh_cfg.sv @@
// Configuration registers: homing speed, backoff count and drive current.
`default_nettype none

module teh_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [teh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [teh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output teh_pkg::t_cfg                       o_cfg
);
    import teh_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HOMING_SPEED:  n_cfg.homing_speed  = i_cfg_data[SPEED_W-1:0];
                CFG_BACKOFF_COUNT: n_cfg.backoff_count = i_cfg_data[BOFF_W-1:0];
                CFG_DRIVE_CURRENT: n_cfg.drive_current = i_cfg_data[CUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.homing_speed  <= SPEED_RST;
            r_cfg.backoff_count <= BOFF_RST;
            r_cfg.drive_current <= CUR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/teh_in_reg.sv @@
// Input register that captures one control tick per transfer.
`default_nettype none

module teh_in_reg (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    teh_in_if.sink       i_in,
    input  wire logic    i_advance,
    output logic         o_valid,
    output teh_pkg::t_in_item o_item
);
    import teh_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Room exists when empty or when the held tick moves on this cycle.
    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.mode        <= i_in.mode;
            r_item.endstop_one <= i_in.endstop_one;
            r_item.endstop_two <= i_in.endstop_two;
            r_item.position    <= i_in.position;
            r_item.motor_busy  <= i_in.motor_busy;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ design/teh_seq.sv @@
// Homing sequencer state and the combinational step logic for one tick.
`default_nettype none

module teh_seq (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire teh_pkg::t_in_item i_item,
    input  wire teh_pkg::t_cfg     i_cfg,
    output teh_pkg::t_result  o_result
);
    import teh_pkg::*;

    t_phase                  r_phase;
    t_phase                  n_phase;
    t_status                 r_status;
    t_status                 n_status;
    logic signed [BT_W-1:0]  r_backoff_target;
    logic signed [BT_W-1:0]  n_backoff_target;
    logic signed [POS_W-1:0] r_travel;
    logic signed [POS_W-1:0] n_travel;
    logic                    r_cal;
    logic                    n_cal;

    logic signed [BT_W-1:0]  pos_ext;
    logic signed [BT_W-1:0]  boff_ext;
    logic signed [BT_W-1:0]  fwd_target;
    logic signed [BT_W-1:0]  rev_target;
    logic                    back1_reached;
    logic                    back2_reached;
    logic signed [POS_W-1:0] travel_adj;
    logic signed [POS_W-1:0] center;

    t_cmd                    cmd;
    logic                    fwd;
    logic signed [POS_W-1:0] target;
    logic                    zero;
    logic                    save;
    logic                    dirty;

    assign pos_ext  = {{(BT_W-POS_W){i_item.position[POS_W-1]}}, i_item.position};
    assign boff_ext = {{(BT_W-BOFF_W){1'b0}}, i_cfg.backoff_count};

    assign fwd_target    = pos_ext + boff_ext;
    assign rev_target    = pos_ext - boff_ext;
    assign back1_reached = (pos_ext >= r_backoff_target);
    assign back2_reached = (pos_ext <= r_backoff_target);

    // Halving that truncates toward zero: bias negative values by one first.
    assign travel_adj = r_travel + $signed({{(POS_W-1){1'b0}}, r_travel[POS_W-1]});
    assign center     = travel_adj >>> 1;

    // Next state.
    always_comb begin
        n_phase          = r_phase;
        n_status         = r_status;
        n_backoff_target = r_backoff_target;
        n_travel         = r_travel;
        n_cal            = r_cal;
        if (i_step) begin
            unique case (t_mode'(i_item.mode))
                MODE_START: begin
                    n_status = ST_HOMING;
                    n_phase  = PH_SEEK1;
                end
                MODE_ABORT: begin
                    n_status = ST_IDLE;
                    n_phase  = PH_IDLE;
                end
                MODE_UPDATE: begin
                    unique case (r_phase)
                        PH_SEEK1: begin
                            // An endstop two hit here is a wiring or direction fault.
                            if (i_item.endstop_two) begin
                                n_phase  = PH_IDLE;
                                n_status = ST_ERROR;
                            end else if (i_item.endstop_one) begin
                                n_backoff_target = fwd_target;
                                n_phase          = PH_BACK1;
                            end
                        end
                        PH_BACK1: begin
                            if (back1_reached) begin
                                n_phase = PH_SEEK2;
                            end
                        end
                        PH_SEEK2: begin
                            if (i_item.endstop_two) begin
                                n_travel         = i_item.position;
                                n_backoff_target = rev_target;
                                n_phase          = PH_BACK2;
                            end
                        end
                        PH_BACK2: begin
                            if (back2_reached) begin
                                n_phase = PH_CENTER;
                            end
                        end
                        PH_CENTER: begin
                            if (!i_item.motor_busy) begin
                                n_phase  = PH_DONE;
                                n_cal    = 1'b1;
                                n_status = ST_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Commands and pulses of this tick.
    always_comb begin
        cmd    = CMD_NONE;
        fwd    = 1'b0;
        target = '0;
        zero   = 1'b0;
        save   = 1'b0;
        dirty  = 1'b0;
        unique case (t_mode'(i_item.mode))
            MODE_START: begin
                cmd = CMD_ENABLE_RUN;
            end
            MODE_ABORT: begin
                cmd   = CMD_STOP;
                dirty = 1'b1;
            end
            MODE_UPDATE: begin
                unique case (r_phase)
                    PH_SEEK1: begin
                        if (i_item.endstop_two) begin
                            cmd = CMD_STOP;
                        end else if (i_item.endstop_one) begin
                            cmd = CMD_STOP_RUN;
                            fwd = 1'b1;
                        end
                    end
                    PH_BACK1: begin
                        if (back1_reached) begin
                            cmd  = CMD_STOP_RUN;
                            fwd  = 1'b1;
                            zero = 1'b1;
                        end
                    end
                    PH_SEEK2: begin
                        if (i_item.endstop_two) begin
                            cmd = CMD_STOP_RUN;
                        end
                    end
                    PH_BACK2: begin
                        if (back2_reached) begin
                            cmd    = CMD_STOP_MOVE;
                            target = center;
                        end
                    end
                    PH_CENTER: begin
                        if (!i_item.motor_busy) begin
                            save  = 1'b1;
                            dirty = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_status         <= ST_IDLE;
            r_backoff_target <= '0;
            r_travel         <= '0;
            r_cal            <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_status         <= n_status;
            r_backoff_target <= n_backoff_target;
            r_travel         <= n_travel;
            r_cal            <= n_cal;
        end
    end

    always_comb begin
        o_result.phase             = n_phase;
        o_result.status            = n_status;
        o_result.motor_cmd         = cmd;
        o_result.motor_forward     = fwd;
        o_result.motor_speed       = i_cfg.homing_speed;
        o_result.target_position   = target;
        o_result.zero_position     = zero;
        o_result.travel_distance   = n_travel;
        o_result.calibrated        = n_cal;
        o_result.save_calibration  = save;
        o_result.display_dirty     = dirty;
        o_result.drive_current_out = i_cfg.drive_current;
    end

endmodule

`default_nettype wire

@@ design/teh_out_reg.sv @@
// Result register that holds one homing result until its transfer.
`default_nettype none

module teh_out_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire teh_pkg::t_result i_result,
    output logic             o_space,
    teh_out_if.source        o_out
);
    import teh_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.phase             = r_result.phase;
    assign o_out.status            = r_result.status;
    assign o_out.motor_cmd         = r_result.motor_cmd;
    assign o_out.motor_forward     = r_result.motor_forward;
    assign o_out.motor_speed       = r_result.motor_speed;
    assign o_out.target_position   = r_result.target_position;
    assign o_out.zero_position     = r_result.zero_position;
    assign o_out.travel_distance   = r_result.travel_distance;
    assign o_out.calibrated        = r_result.calibrated;
    assign o_out.save_calibration  = r_result.save_calibration;
    assign o_out.display_dirty     = r_result.display_dirty;
    assign o_out.drive_current_out = r_result.drive_current_out;

endmodule

`default_nettype wire
